FILE: src/efpd_pkg.sv
`timescale 1ns / 1ps

package efpd_pkg;

  localparam int unsigned NUM_ENCODERS = 3;
  localparam int unsigned REPORTED     = 3;

  localparam int unsigned PARSE_W = $clog2(2 * NUM_ENCODERS + 2);

  localparam logic [7:0] SYNC_FIRST  = 8'h0A;
  localparam logic [7:0] SYNC_SECOND = 8'h0D;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef logic [NUM_ENCODERS-1:0][15:0] count_arr_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic               frame_ready;
    logic               deltas_valid;
    logic signed [15:0] delta_first;
    logic signed [15:0] delta_second;
    logic signed [15:0] delta_third;
  } out_item_t;

endpackage

FILE: src/efpd_parser.sv
`timescale 1ns / 1ps

module efpd_parser import efpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  output logic       frame_done_o,
  output count_arr_t count_d_o
);

  localparam logic [PARSE_W-1:0] ST_SYNC_A = PARSE_W'(0);
  localparam logic [PARSE_W-1:0] ST_SYNC_B = PARSE_W'(1);
  localparam logic [PARSE_W-1:0] ST_LAST   = PARSE_W'(2 * NUM_ENCODERS + 1);

  logic [PARSE_W-1:0] state_q, state_d, state_eff;
  logic [NUM_ENCODERS-1:0][7:0] low_q, low_d;
  count_arr_t count_q, count_d;

  always_comb begin
    state_eff    = (state_q > ST_LAST) ? ST_SYNC_A : state_q;
    state_d      = state_q;
    low_d        = low_q;
    count_d      = count_q;
    frame_done_o = 1'b0;
    if (byte_valid_i) begin
      if (state_eff == ST_SYNC_A) begin
        state_d = (byte_i == SYNC_FIRST) ? ST_SYNC_B : ST_SYNC_A;
      end else if (state_eff == ST_SYNC_B) begin
        // a bad second sync byte is dropped, not retried as a first sync
        state_d = (byte_i == SYNC_SECOND) ? PARSE_W'(2) : ST_SYNC_A;
      end else begin
        for (int unsigned i = 0; i < NUM_ENCODERS; i++) begin
          if (state_eff == PARSE_W'(2 + 2 * i)) begin
            low_d[i] = byte_i;
          end
          if (state_eff == PARSE_W'(3 + 2 * i)) begin
            count_d[i] = {byte_i, low_q[i]};
          end
        end
        if (state_eff == ST_LAST) begin
          state_d      = ST_SYNC_A;
          frame_done_o = 1'b1;
        end else begin
          state_d = state_eff + PARSE_W'(1);
        end
      end
    end
  end

  assign count_d_o = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SYNC_A;
      low_q   <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      low_q   <= low_d;
      count_q <= count_d;
    end
  end

endmodule

FILE: src/encoder_frame_parser_delta_core.sv
`timescale 1ns / 1ps

// Encoder frame parser with per-tick deltas. Each input transfer is either a
// received serial byte (opcode 0) or an update tick (opcode 1), and each gives
// exactly one result. Frames are 0x0A 0x0D followed by a little-endian 16-bit
// count per encoder; frame_ready flags the byte that ends every second frame,
// and the first such pair also sets the baseline. A tick reports the wrapped
// signed change of each count since the last tick or baseline, and reports
// zeros with deltas_valid low until the baseline exists. One item is taken
// per cycle: all parsing and delta work is done in the accept cycle and the
// result sits in a single output register, and in_ready_o drops only while
// that register holds a result not yet taken.
module encoder_frame_parser_delta_core import efpd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic       accept, byte_valid, tick, frame_done, ready_pulse, deltas_ok;
  count_arr_t count_d;
  count_arr_t base_q, base_d;
  count_arr_t delta;
  logic [REPORTED-1:0][15:0] report;
  logic       pair_q, pair_d;
  logic       pending_q, pending_d;
  logic       out_valid_q;
  out_item_t  out_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign byte_valid = accept && (in_item_i.opcode == OP_BYTE);
  assign tick       = accept && (in_item_i.opcode == OP_TICK);

  efpd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(byte_valid),
    .byte_i      (in_item_i.rx_byte),
    .frame_done_o(frame_done),
    .count_d_o   (count_d)
  );

  assign ready_pulse = frame_done && pair_q;
  assign deltas_ok   = tick && !pending_q;

  always_comb begin
    pair_d    = frame_done ? !pair_q : pair_q;
    pending_d = pending_q;
    base_d    = base_q;
    report    = '0;
    for (int unsigned i = 0; i < NUM_ENCODERS; i++) begin
      delta[i] = count_d[i] - base_q[i];
    end
    if (ready_pulse && pending_q) begin
      pending_d = 1'b0;
      base_d    = count_d;
    end
    if (deltas_ok) begin
      base_d = count_d;
      for (int unsigned i = 0; i < NUM_ENCODERS; i++) begin
        if (i < REPORTED) begin
          report[i] = delta[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q      <= 1'b0;
      pending_q   <= 1'b1;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pair_q    <= pair_d;
      pending_q <= pending_d;
      base_q    <= base_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the result until the output transfer completes
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.frame_ready  <= ready_pulse;
      out_q.deltas_valid <= deltas_ok;
      out_q.delta_first  <= report[0];
      out_q.delta_second <= report[1];
      out_q.delta_third  <= report[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_ready_tick_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.frame_ready && out_item_o.deltas_valid))
    else $error("frame_ready and deltas_valid both set");

  a_baseline_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_pulse |=> !pending_q)
    else $error("baseline still pending after a frame pair");

  a_zero_without_deltas: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.deltas_valid) |->
      (out_item_o.delta_first == 16'sd0 && out_item_o.delta_second == 16'sd0 &&
       out_item_o.delta_third == 16'sd0))
    else $error("nonzero delta without deltas_valid");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled with room in the output register");

endmodule

FILE: test/efpd_delta_checker.sv
`timescale 1ns / 1ps

module efpd_delta_checker import efpd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_count_o
);

  localparam int LAST_CODE = 1 + 2 * NUM_ENCODERS;

  // Mirror of the parser and delta state.
  int         parse_code;
  logic [7:0] low_hold [NUM_ENCODERS];
  count_arr_t counts;
  count_arr_t baseline;
  count_arr_t deltas;
  bit         pair_half;
  bit         baseline_wait;

  out_item_t expected_results[$];

  function automatic out_item_t predict_frame_step(in_item_t item);
    out_item_t   res;
    int          k;
    logic [15:0] shown [3];
    res = '0;
    for (int j = 0; j < 3; j++) shown[j] = '0;
    if (item.opcode == OP_BYTE) begin
      if (parse_code > LAST_CODE) parse_code = 0;
      if (parse_code == 0) begin
        parse_code = (item.rx_byte == SYNC_FIRST) ? 1 : 0;
      end else if (parse_code == 1) begin
        // a bad second sync byte is dropped, not retried as a first sync
        parse_code = (item.rx_byte == SYNC_SECOND) ? 2 : 0;
      end else begin
        k = (parse_code - 2) / 2;
        if ((parse_code - 2) % 2 == 0) begin
          low_hold[k] = item.rx_byte;
          parse_code++;
        end else begin
          counts[k] = {item.rx_byte, low_hold[k]};
          if (parse_code == LAST_CODE) begin
            parse_code = 0;
            if (pair_half) begin
              pair_half = 1'b0;
              res.frame_ready = 1'b1;
              if (baseline_wait) begin
                baseline_wait = 1'b0;
                baseline = counts;
              end
            end else begin
              pair_half = 1'b1;
            end
          end else begin
            parse_code++;
          end
        end
      end
    end else if (!baseline_wait) begin
      for (int i = 0; i < NUM_ENCODERS; i++) begin
        deltas[i] = counts[i] - baseline[i];
      end
      baseline = counts;
      res.deltas_valid = 1'b1;
      for (int j = 0; j < 3 && j < NUM_ENCODERS; j++) shown[j] = deltas[j];
      res.delta_first  = shown[0];
      res.delta_second = shown[1];
      res.delta_third  = shown[2];
    end
    return res;
  endfunction

  // keep unknown bits visible so an X result never passes as zero
  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      parse_code    = 0;
      counts        = '0;
      baseline      = '0;
      deltas        = '0;
      pair_half     = 1'b0;
      baseline_wait = 1'b1;
      for (int i = 0; i < NUM_ENCODERS; i++) low_hold[i] = '0;
      expected_results.delete();
      fail_count_o    = 0;
      pending_count_o = 0;
    end else begin
      // compare the outgoing result first: it cannot belong to this edge's input
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with nothing expected, expected none, got %p",
                   $time, out_item_i);
        end else begin
          want = expected_results.pop_front();
          check_field("frame_ready", want.frame_ready, out_item_i.frame_ready);
          check_field("deltas_valid", want.deltas_valid, out_item_i.deltas_valid);
          check_field("delta_first", want.delta_first, out_item_i.delta_first);
          check_field("delta_second", want.delta_second, out_item_i.delta_second);
          check_field("delta_third", want.delta_third, out_item_i.delta_third);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(predict_frame_step(in_item_i));
      end
      pending_count_o = expected_results.size();
    end
  end

endmodule

FILE: test/encoder_frame_parser_delta_core_test.sv
`timescale 1ns / 1ps

module encoder_frame_parser_delta_core_test;
  import efpd_pkg::*;

  localparam int ITEM_TARGET    = 850;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  localparam logic [15:0] COUNT_EXTREMES [5] =
    '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001};

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  int fail_count;
  int pending_count;
  int sent_items  = 0;
  int idle_cycles = 0;
  bit send_steady = 1'b0;
  bit take_steady = 1'b0;

  always #2 clk = ~clk;

  encoder_frame_parser_delta_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  efpd_delta_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_item_i      (in_item),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_item_i     (out_item),
    .fail_count_o   (fail_count),
    .pending_count_o(pending_count)
  );

  function automatic int draw_gap(input bit steady);
    return steady ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic logic [15:0] pick_count();
    if ($urandom_range(0, 4) == 0) return COUNT_EXTREMES[$urandom_range(0, 4)];
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // Hold valid until the transfer; returns just after the accepting edge.
  task automatic transfer_item(input in_item_t item);
    int gap;
    if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
    gap = draw_gap(send_steady);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  task automatic send_byte(input logic [7:0] value);
    in_item_t item;
    item.opcode  = OP_BYTE;
    item.rx_byte = value;
    transfer_item(item);
  endtask

  task automatic send_tick(input logic [7:0] filler);
    in_item_t item;
    item.opcode  = OP_TICK;
    item.rx_byte = filler;
    transfer_item(item);
  endtask

  task automatic send_frame(input count_arr_t frame_counts);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    for (int k = 0; k < NUM_ENCODERS; k++) begin
      send_byte(frame_counts[k][7:0]);
      send_byte(frame_counts[k][15:8]);
    end
  endtask

  // Receiver: stall for a random gap, or none in steady mode, before each result.
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) take_steady = !take_steady;
      gap = draw_gap(take_steady);
      if (gap > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    count_arr_t frame_counts;
    int         kind;
    int         tail;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // tick before any baseline exists
    send_tick(8'hFF);
    // bad second sync byte, then a 0x0D that must not sync
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    for (int k = 0; k < NUM_ENCODERS; k++) frame_counts[k] = COUNT_EXTREMES[k % 5];
    send_frame(frame_counts);
    // second frame of the pair latches the baseline
    for (int k = 0; k < NUM_ENCODERS; k++) frame_counts[k] = COUNT_EXTREMES[(k + 3) % 5];
    send_frame(frame_counts);
    send_tick(8'h00);

    while (sent_items < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        for (int k = 0; k < NUM_ENCODERS; k++) frame_counts[k] = pick_count();
        send_frame(frame_counts);
      end else if (kind < 8) begin
        send_tick(8'($urandom_range(0, 255)));
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else if ($urandom_range(0, 1) == 0) begin
        send_byte(SYNC_FIRST);
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        // truncated frame: the next sync may land inside its count bytes
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        tail = $urandom_range(0, 2 * NUM_ENCODERS - 1);
        repeat (tail) send_byte(8'($urandom_range(0, 255)));
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/efpd_pkg.sv
src/efpd_parser.sv
src/encoder_frame_parser_delta_core.sv
test/efpd_delta_checker.sv
test/encoder_frame_parser_delta_core_test.sv
